// ===== design/sfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;
  localparam int MAX_TAPS   = 64;
  localparam int TAP_W      = $clog2(MAX_TAPS);
  localparam int CNT_W      = $clog2(MAX_TAPS + 1);
  localparam int DATA_W     = 16;
  localparam int TCNT_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = DATA_W / DIGIT_W;
  localparam int DIDX_W     = $clog2(NUM_DIGITS);
  localparam int PP_W       = DATA_W + DIGIT_W + 1;
  localparam int ACC_W      = 2 * DATA_W + TAP_W + 1;
  localparam int ADDR_W     = 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic              first;
    logic [DIDX_W-1:0] digit;
  } mac_ctrl_t;
endpackage
`default_nettype wire

// ===== design/sfc_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfc_mac (
  input  wire                              clk,
  input  sfc_pkg::mac_ctrl_t               ctrl,
  input  wire signed [sfc_pkg::DATA_W-1:0] coef_in,
  input  wire signed [sfc_pkg::DATA_W-1:0] sample_in,
  output logic signed [sfc_pkg::ACC_W-1:0] acc
);
  import sfc_pkg::*;

  logic signed [DATA_W-1:0] c_r;
  logic signed [DATA_W-1:0] x_sh_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DATA_W-1:0]  c_use;
  logic signed [DATA_W-1:0]  x_use;
  logic        [DIGIT_W-1:0] d;
  logic signed [DIGIT_W:0]   d_s;
  logic signed [PP_W-1:0]    pp;
  logic signed [ACC_W-1:0]   pp_ext;

  always_comb begin
    c_use = ctrl.first ? coef_in : c_r;
    x_use = ctrl.first ? sample_in : x_sh_r;
    d = x_use[DIGIT_W-1:0];
    // top digit carries the sample's sign, lower digits are unsigned
    if (ctrl.digit == DIDX_W'(NUM_DIGITS - 1)) begin
      d_s = {d[DIGIT_W-1], d};
    end else begin
      d_s = {1'b0, d};
    end
    pp = PP_W'(c_use) * PP_W'(d_s);
    pp_ext = ACC_W'(pp) <<< (ctrl.digit * DIGIT_W);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r  <= acc_r + pp_ext;
      c_r    <= c_use;
      x_sh_r <= x_use >>> DIGIT_W;
    end
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

// ===== design/streaming_fir_convolver_top.sv =====
// Load request: one per cycle while no sample request is in progress.
// Sample request: the result is registered after all n taps, n = min(tap_count, 64);
// no new request is taken until the result is registered. Each tap takes one
// coefficient/history memory read plus four 4-bit digit steps of the shared MAC.
// Synchronous active-low reset: coefficients and history read as zero, tap_count = 64.
`timescale 1ns / 1ps
`default_nettype none
module streaming_fir_convolver_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_cmd,
  input  wire [sfc_pkg::TAP_W-1:0]         in_tap_index,
  input  wire signed [sfc_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [sfc_pkg::DATA_W-1:0] out_filtered,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [sfc_pkg::ADDR_W-1:0]        paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sfc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_MUL, S_ROUND} state_t;

  state_t               state_r;
  logic [TCNT_W-1:0]    tap_count_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     tap_r;
  logic [DIDX_W-1:0]    dcnt_r;
  logic [TAP_W-1:0]     wp_r;
  logic [TAP_W-1:0]     base_r;
  logic                 out_valid_r;
  logic signed [DATA_W-1:0] out_filtered_r;

  logic [DATA_W-1:0]    coef_mem [MAX_TAPS];
  logic [DATA_W-1:0]    hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]  coef_valid_r;
  logic [MAX_TAPS-1:0]  hist_valid_r;
  logic [DATA_W-1:0]    coef_q_r;
  logic [DATA_W-1:0]    hist_q_r;
  logic                 coef_vq_r;
  logic                 hist_vq_r;

  logic                 acc_in;
  logic                 load_req;
  logic                 samp_req;
  logic [TAP_W-1:0]     c_addr;
  logic [TAP_W-1:0]     h_addr;
  logic [CNT_W-1:0]     n_sel;
  mac_ctrl_t            mac_ctrl;
  logic signed [DATA_W-1:0] coef_rd;
  logic signed [DATA_W-1:0] hist_rd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [DATA_W-1:0] sat;
  logic                 cfg_wr;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign load_req = acc_in && (in_cmd == CMD_LOAD);
  assign samp_req = acc_in && (in_cmd == CMD_SAMPLE);
  assign c_addr   = tap_r[TAP_W-1:0];
  assign h_addr   = base_r - tap_r[TAP_W-1:0];
  assign n_sel    = (tap_count_r > TCNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_r);
  assign coef_rd  = coef_vq_r ? $signed(coef_q_r) : '0;
  assign hist_rd  = hist_vq_r ? $signed(hist_q_r) : '0;

  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - TCNT_W){1'b0}}, tap_count_r};

  always_comb begin
    mac_ctrl.clear = samp_req;
    mac_ctrl.step  = (state_r == S_MUL);
    mac_ctrl.first = (dcnt_r == '0);
    mac_ctrl.digit = dcnt_r;
  end

  sfc_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .coef_in   (coef_rd),
    .sample_in (hist_rd),
    .acc       (acc)
  );

  // round half up, then clamp to Q1.15
  always_comb begin
    rnd = (acc + ACC_W'(16384)) >>> 15;
    if (rnd > ACC_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (rnd < -ACC_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_req) begin
      coef_mem[in_tap_index] <= in_value;
    end
    if (samp_req) begin
      hist_mem[wp_r] <= in_value;
    end
    coef_q_r  <= coef_mem[c_addr];
    hist_q_r  <= hist_mem[h_addr];
    coef_vq_r <= coef_valid_r[c_addr];
    hist_vq_r <= hist_valid_r[h_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_valid_r <= '0;
      hist_valid_r <= '0;
      tap_count_r  <= TCNT_W'(MAX_TAPS);
    end else begin
      if (load_req) begin
        coef_valid_r[in_tap_index] <= 1'b1;
      end
      if (samp_req) begin
        hist_valid_r[wp_r] <= 1'b1;
      end
      if (cfg_wr) begin
        tap_count_r <= pwdata[TCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      tap_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      // in S_ROUND the result register is refilled below instead
      if (out_valid_r && out_ready && state_r != S_ROUND) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (samp_req) begin
            base_r <= wp_r;
            wp_r   <= wp_r + 1'b1;
            n_r    <= n_sel;
            tap_r  <= '0;
            dcnt_r <= '0;
            state_r <= (n_sel == '0) ? S_ROUND : S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DIDX_W'(NUM_DIGITS - 1)) begin
            if (tap_r + 1'b1 == n_r) begin
              state_r <= S_ROUND;
            end else begin
              tap_r   <= tap_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_ROUND: begin
          if (!out_valid_r || out_ready) begin
            out_filtered_r <= sat;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

`ifndef SYNTH
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_MUL) |-> (tap_r < n_r))
    else $error("tap index beyond tap count");
  a_rd_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (dcnt_r == '0))
    else $error("digit counter not reset at tap fetch");
  a_hist_marked: assert property (@(posedge clk) disable iff (!rst_n)
    samp_req |=> hist_valid_r[$past(wp_r)])
    else $error("history entry not marked valid");
  a_round_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && out_valid_r && !out_ready) |=> (state_r == S_ROUND))
    else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire

// ===== test/streaming_fir_convolver_top_tb.sv =====
`timescale 1ns / 1ps
module streaming_fir_convolver_top_tb;
  import sfc_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam longint CYCLE_LIMIT = 64'd4000000;
  localparam logic [ADDR_W-1:0] REG_TAP_COUNT = 3'd0;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic [TAP_W-1:0] in_tap_index;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_filtered;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  streaming_fir_convolver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_tap_index(in_tap_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_filtered(out_filtered),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // filter model state
  logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];
  logic signed [DATA_W-1:0] hist_mem [MAX_TAPS-1];
  logic [TCNT_W-1:0] taps_cfg;

  logic signed [DATA_W-1:0] pending_filtered [$];
  int mismatches = 0;
  int samples_sent;
  int loads_sent;
  int results_seen = 0;
  longint cycle_count = 0;
  bit hold_rx = 1'b0;
  bit rx_pressured = 1'b0;

  typedef struct {
    logic cmd;
    logic [TAP_W-1:0] idx;
    logic signed [DATA_W-1:0] val;
    bit known;
    logic signed [DATA_W-1:0] want;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] fir_output(
      input logic signed [DATA_W-1:0] x);
    int n;
    longint acc;
    longint q;
    n = (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
    acc = 0;
    for (int k = 0; k < n; k++)
      acc += longint'(coef_mem[k]) * longint'((k == 0) ? x : hist_mem[k-1]);
    q = (acc + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[DATA_W-1:0];
  endfunction

  function automatic bit model_apply(input logic cmd, input logic [TAP_W-1:0] idx,
      input logic signed [DATA_W-1:0] val, output logic signed [DATA_W-1:0] y);
    if (cmd == CMD_LOAD) begin
      coef_mem[idx] = val;
      return 1'b0;
    end
    y = fir_output(val);
    for (int k = MAX_TAPS - 2; k > 0; k--) hist_mem[k] = hist_mem[k-1];
    hist_mem[0] = val;
    return 1'b1;
  endfunction

  // sends one request and queues its expected output, if any
  task automatic send_request(input logic cmd, input logic [TAP_W-1:0] idx,
      input logic signed [DATA_W-1:0] val, input bit known,
      input logic signed [DATA_W-1:0] want);
    logic signed [DATA_W-1:0] y;
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 4);
    // valid stays up across back-to-back requests
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_tap_index <= idx;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    if (model_apply(cmd, idx, val, y)) begin
      if (known && y !== want)
        $display("note: table row value %0d differs from model %0d", want, y);
      pending_filtered = {pending_filtered, (known ? want : y)};
      samples_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    // last accepted load may still be settling
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [TCNT_W-1:0] n);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TAP_COUNT;
    pwdata <= 32'(n);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    taps_cfg = n;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_filtered.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_filtered);
      end else begin
        logic signed [DATA_W-1:0] want;
        want = pending_filtered.pop_front();
        if (out_filtered !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("filtered mismatch: expected %0d got %0d", want, out_filtered);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
        rx_pressured = 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b0;
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 3);
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t rows [14];
    logic signed [DATA_W-1:0] none;
    int sent;
    int mode;
    logic [TCNT_W-1:0] settings [6];
    settings = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd8, 7'd3};
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_SAMPLE;
    in_tap_index = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_sent = 0;
    loads_sent = 0;
    taps_cfg = 7'd64;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero coefs after reset, extremes, saturation, unity tap
    rows = '{
      '{CMD_SAMPLE, 6'd0, 16'sh7fff, 1, 16'sd0},
      '{CMD_SAMPLE, 6'd63, -16'sd32768, 1, 16'sd0},
      '{CMD_LOAD, 6'd0, 16'sh7fff, 0, none},
      '{CMD_SAMPLE, 6'd0, 16'sh7fff, 0, none},
      '{CMD_SAMPLE, 6'd0, -16'sd32768, 0, none},
      '{CMD_LOAD, 6'd0, -16'sd32768, 0, none},
      '{CMD_SAMPLE, 6'd0, -16'sd32768, 1, 16'sd32767},
      '{CMD_SAMPLE, 6'd0, 16'sh7fff, 1, -16'sd32767},
      '{CMD_LOAD, 6'd63, -16'sd32768, 0, none},
      '{CMD_LOAD, 6'd1, -16'sd32768, 0, none},
      '{CMD_SAMPLE, 6'd0, -16'sd32768, 0, none},
      '{CMD_SAMPLE, 6'd21, 16'sd1, 0, none},
      '{CMD_LOAD, 6'd42, 16'sh5555, 0, none},
      '{CMD_SAMPLE, 6'd42, -16'sh5556, 0, none}
    };
    foreach (rows[i])
      send_request(rows[i].cmd, rows[i].idx, rows[i].val, rows[i].known, rows[i].want);
    drain();

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_tap_count(settings[phase]);
      if (phase == 3) hold_rx = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        logic signed [DATA_W-1:0] v;
        mode = $urandom_range(0, 9);
        v = (mode == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : -16'sd32768) :
            DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0)
          send_request(CMD_LOAD, TAP_W'($urandom), v, 0, none);
        else
          send_request(CMD_SAMPLE, TAP_W'($urandom), v, 0, none);
        sent++;
      end
      drain();
    end

    $display("run covered %0d samples and %0d coefficient loads, %0d results checked",
             samples_sent, loads_sent, results_seen);
    $display("tap counts swept 0..127 with a long output stall (done=%0d)", rx_pressured);
    if (mismatches == 0 && pending_filtered.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== streaming_fir_convolver_top.f =====
design/sfc_pkg.sv
design/sfc_mac.sv
design/streaming_fir_convolver_top.sv
test/streaming_fir_convolver_top_tb.sv
